// File: design/tdpt_pkg.sv
package tdpt_pkg;

  localparam int unsigned NumberWidth = 31;
  localparam int unsigned InDataWidth = ((NumberWidth + 7) / 8) * 8;
  localparam int unsigned OutDataWidth = 8;
  // odd divisors stay at or just above sqrt(2^NumberWidth)
  localparam int unsigned DivWidth = NumberWidth / 2 + 2;
  // square of the divisor, one step past the square root at most
  localparam int unsigned SqWidth = NumberWidth + 1;
  localparam int unsigned CntWidth = $clog2(NumberWidth);

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

// File: design/tdpt_rem.sv
// Bit-serial restoring remainder: one dividend bit enters per cycle.
module tdpt_rem (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [tdpt_pkg::NumberWidth-1:0]    dividend_i,
  input  logic [tdpt_pkg::NumberWidth-1:0]    divisor_i,
  output tdpt_pkg::rem_status_t               status_o
);

  localparam int unsigned W = tdpt_pkg::NumberWidth;

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [tdpt_pkg::CntWidth-1:0]     cnt_q, cnt_d;
  logic [W-1:0]                      shift_q, shift_d;
  logic [W-1:0]                      rem_q, rem_d;
  logic [W-1:0]                      div_q, div_d;
  logic [W:0]                        trial;
  logic [W:0]                        diff;

  assign trial = {rem_q, shift_q[W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = tdpt_pkg::CntWidth'(W - 1);
      shift_d = dividend_i;
      rem_d   = '0;
      div_d   = divisor_i;
    end else if (busy_q) begin
      shift_d = {shift_q[W-2:0], 1'b0};
      // no borrow: the trial value holds at least one divisor
      rem_d   = diff[W] ? trial[W-1:0] : diff[W-1:0];
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
  end

  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

endmodule

// File: design/trial_division_prime_test.sv
// Trial-division primality test. Each input item is one unsigned number; the block
// answers with one item whose bit 0 is 1 when the number is prime (0 and 1 are not
// prime). Even numbers and numbers below three are decided at input, with no try.
// Otherwise the odd divisors 3, 5, 7, ... are tried while their square does not exceed
// the number; each try runs through a bit-serial remainder unit that takes one dividend
// bit per cycle. A prime near 2^31 takes about 23,000 tries; a composite stops at its
// smallest factor. One number is tested at a time; a new number is taken as soon as
// the previous answer sits in the output register.
module trial_division_prime_test (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [30:0] number, [31] fill, ignored
  input  logic [tdpt_pkg::InDataWidth-1:0]      s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [0] is_prime, [7:1] zero fill
  output logic [tdpt_pkg::OutDataWidth-1:0]     m_axis_tdata_o
);

  localparam int unsigned W  = tdpt_pkg::NumberWidth;
  localparam int unsigned DW = tdpt_pkg::DivWidth;
  localparam int unsigned SW = tdpt_pkg::SqWidth;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StCheck  = 2'd1;
  localparam logic [1:0] StWait   = 2'd2;
  localparam logic [1:0] StResult = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [W-1:0]  n_q, n_d;
  logic [DW-1:0] d_q, d_d;
  logic [SW-1:0] sq_q, sq_d;
  logic          prime_q, prime_d;
  logic          out_valid_q, out_valid_d;
  logic          out_prime_q, out_prime_d;

  logic          in_fire;
  logic          rem_start;
  logic          past_root;
  logic [W-1:0]  in_number;
  tdpt_pkg::rem_status_t rem_status;

  assign in_number = s_axis_tdata_i[W-1:0];
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign past_root = (sq_q > {1'b0, n_q});
  assign rem_start = (state_q == StCheck) && !past_root;

  tdpt_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (n_q),
    .divisor_i  (W'(d_q)),
    .status_o   (rem_status)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    sq_d        = sq_q;
    prime_d     = prime_q;
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;

    if (m_axis_tvalid_o && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          n_d  = in_number;
          d_d  = DW'(3);
          sq_d = SW'(9);
          if (in_number[W-1:1] == '0) begin
            prime_d = 1'b0;
            state_d = StResult;
          end else if (in_number == W'(2)) begin
            prime_d = 1'b1;
            state_d = StResult;
          end else if (!in_number[0]) begin
            prime_d = 1'b0;
            state_d = StResult;
          end else begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (past_root) begin
          prime_d = 1'b1;
          state_d = StResult;
        end else begin
          state_d = StWait;
        end
      end
      StWait: begin
        if (rem_status.done) begin
          if (rem_status.zero) begin
            prime_d = 1'b0;
            state_d = StResult;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            sq_d    = sq_q + (SW'(d_q) << 2) + SW'(4);
            d_d     = d_q + DW'(2);
            state_d = StCheck;
          end
        end
      end
      StResult: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_prime_d = prime_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    prime_q     <= prime_d;
    out_prime_q <= out_prime_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(tdpt_pkg::OutDataWidth - 1){1'b0}}, out_prime_q};

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MaxNumber = (1 << tdpt_pkg::NumberWidth) - 1;
  localparam int unsigned FirstDivisor = 2;
  localparam int unsigned CycleLimit = 8_000_000;
  localparam int unsigned MaxReported = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [tdpt_pkg::InDataWidth-1:0]  s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [tdpt_pkg::OutDataWidth-1:0] m_tdata;

  // numbers waiting to be driven, and prime flags waiting for their result
  logic [tdpt_pkg::InDataWidth-1:0] number_q[$];
  bit                               prime_flag_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned numbers_sent = 0;
  int unsigned results_seen = 0;
  int unsigned primes_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          want_flag;

  trial_division_prime_test u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // odd divisors up to the square root; d <= n / d avoids the square
  function automatic bit trial_div_prime(logic [tdpt_pkg::InDataWidth-1:0] word);
    longint unsigned n;
    longint unsigned d;
    n = word[tdpt_pkg::NumberWidth-1:0];
    if (n < FirstDivisor) return 1'b0;
    if (n == FirstDivisor) return 1'b1;
    if (n % FirstDivisor == 0) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly small numbers; large ones carry a small factor so no item runs long.
  function automatic logic [tdpt_pkg::InDataWidth-1:0] random_number();
    int unsigned factor;
    int unsigned mult;
    logic [tdpt_pkg::InDataWidth-1:0] word;
    case ($urandom_range(3))
      0, 1: word = $urandom_range(4095);
      2: word = $urandom_range((1 << 20) - 1);
      default: begin
        factor = $urandom_range(255, 3);
        mult = $urandom_range(MaxNumber / factor, 2);
        word = factor * mult;
      end
    endcase
    // upper fill bits must be ignored
    if ($urandom_range(7) == 0)
      word[tdpt_pkg::InDataWidth-1:tdpt_pkg::NumberWidth] = '1;
    return word;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (number_q.size() != 0 || s_tvalid || prime_flag_q.size() != 0);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) number_q.push_back(random_number());
  endtask

  // sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        prime_flag_q.push_back(trial_div_prime(s_tdata));
        numbers_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (number_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= number_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tdata[0]) primes_seen++;
        if (prime_flag_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReported)
            $display("ERROR: result item with no number pending, is_prime=%0b", m_tdata[0]);
        end else begin
          want_flag = prime_flag_q.pop_front();
          if (m_tdata[0] !== want_flag) begin
            fail_count++;
            if (fail_count <= MaxReported)
              $display("ERROR: result %0d is_prime expected %0b got %0b",
                       results_seen, want_flag, m_tdata[0]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d numbers still awaiting a result",
               cycle_count, prime_flag_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // phase 1: sender idles lightly, receiver stalls often
    src_idle_pct = 16;
    sink_idle_pct = 66;
    number_q.push_back(32'd0);
    number_q.push_back(32'd1);
    number_q.push_back(32'd2);
    number_q.push_back(32'd3);
    number_q.push_back(32'd4);
    number_q.push_back(32'd5);
    number_q.push_back(32'd9);         // divisor squared equals the number
    number_q.push_back(32'd25);
    number_q.push_back(32'd49);
    number_q.push_back(32'd121);
    number_q.push_back(32'd97);
    number_q.push_back(32'd65521);     // largest 16-bit prime
    number_q.push_back(32'd65535);
    number_q.push_back(32'd1073741824);
    number_q.push_back(32'd1431655765);
    number_q.push_back(32'd715827882);
    number_q.push_back(MaxNumber - 1);
    number_q.push_back(MaxNumber);     // prime, the longest search
    number_q.push_back({1'b1, 31'd7});
    number_q.push_back({1'b1, 31'd0});
    number_q.push_back({1'b1, 31'd2});
    queue_random(24);
    wait_drained();

    // phase 2: roles swapped
    src_idle_pct = 66;
    sink_idle_pct = 16;
    queue_random(28);
    wait_drained();

    // phase 3: back to back
    src_idle_pct = 0;
    sink_idle_pct = 0;
    queue_random(27);
    wait_drained();
    repeat (100) @(posedge clk);

    $display("%0d numbers tested, %0d results with %0d primes reported", numbers_sent,
             results_seen, primes_seen);
    $display("edge values, masked fill bits and random small to 31-bit inputs, three stall mixes");
    if (fail_count == 0 && prime_flag_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, prime_flag_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/tdpt_pkg.sv
design/tdpt_rem.sv
design/trial_division_prime_test.sv
verif/tb.sv
